// ----- hdl/swf_pkg.sv -----
// ---------------------------------------------------------------------------
// swf_pkg
// Shared constants, types and helper functions of the shallow water flux unit.
// ---------------------------------------------------------------------------
`default_nettype none

package swf_pkg;

   // fixed point format
   localparam int FRAC_BITS = 16;
   localparam int P_SHIFT   = 2 * FRAC_BITS + 1;

   // bound on the pressure magnitude, the pressure term saturates beyond it
   localparam logic [63:0] PCLAMP = 64'h4000_0001_0000_0000;

   // divider geometry: quotient bits retired per stage
   localparam int DIV_WIDTH  = 64;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = DIV_WIDTH / DIV_BITS;
   // magnitude register, step stages, sign restore register
   localparam int DIV_LAT    = DIV_STAGES + 2;
   // register stages of the pressure path
   localparam int P_LAT      = 5;
   localparam int P_DELAY    = DIV_LAT - P_LAT;

   // register indexes
   localparam logic [1:0] CSR_WET_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_GRAVITY       = 2'd1;
   localparam logic [1:0] CSR_INCLUDE_BED   = 2'd2;

   // reset values
   localparam logic [30:0] WET_THRESHOLD_RST = 31'd7;
   localparam logic [30:0] GRAVITY_RST       = 31'd642908;
   localparam logic        INCLUDE_BED_RST   = 1'b1;

   // one stage of the restoring divider
   typedef struct packed {
      logic [31:0]          rem;
      logic [DIV_WIDTH-1:0] work;
      logic [30:0]          divisor;
      logic                 neg;
   } div_stage_type;

   // retire DIV_BITS quotient bits
   function automatic div_stage_type div_step(div_stage_type s);
      div_stage_type t;
      logic [32:0]   trial;
      t = s;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial = {t.rem, t.work[DIV_WIDTH-1]} - {2'b00, t.divisor};
         if (!trial[32]) begin
            t.rem  = trial[31:0];
            t.work = {t.work[DIV_WIDTH-2:0], 1'b1};
         end else begin
            t.rem  = {t.rem[30:0], t.work[DIV_WIDTH-1]};
            t.work = {t.work[DIV_WIDTH-2:0], 1'b0};
         end
      end
      return t;
   endfunction

   // clip to the signed 32-bit range, bit 32 of the result is the clip flag
   function automatic logic [32:0] sat32(logic signed [64:0] v);
      logic [32:0] r;
      if (v > 65'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -65'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/swf_div_pipe.sv -----
// ---------------------------------------------------------------------------
// swf_div_pipe
// Pipelined signed divide of a 64-bit dividend by a positive 31-bit divisor,
// truncating toward zero, a few quotient bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module swf_div_pipe (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [63:0] dividend,
   input  wire logic        [30:0] divisor,
   output logic signed      [63:0] quotient
);

   swf_pkg::div_stage_type       st_ff [0:swf_pkg::DIV_STAGES];
   logic signed [63:0]           quot_ff;
   logic                         neg_in;

   assign neg_in = dividend[63];

   // magnitude, step stages and sign restore
   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0].rem     <= '0;
         st_ff[0].work    <= neg_in ? (64'd0 - dividend) : dividend;
         st_ff[0].divisor <= divisor;
         st_ff[0].neg     <= neg_in;
         for (int k = 1; k <= swf_pkg::DIV_STAGES; k++) begin
            st_ff[k] <= swf_pkg::div_step(st_ff[k-1]);
         end
         quot_ff <= st_ff[swf_pkg::DIV_STAGES].neg ?
                    (64'd0 - st_ff[swf_pkg::DIV_STAGES].work) :
                    st_ff[swf_pkg::DIV_STAGES].work;
      end
   end

   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ----- hdl/swf_pressure.sv -----
// ---------------------------------------------------------------------------
// swf_pressure
// Pressure term g*(h*h - z*z)/2^(2F+1), truncated toward zero and clamped,
// in five register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module swf_pressure (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [63:0] hh,
   input  wire logic signed [63:0] zz,
   input  wire logic        [30:0] gravity,
   output logic signed      [63:0] pressure
);

   logic signed [63:0] diff_ff;
   logic        [63:0] mag_ff;
   logic               neg_a_ff, neg_b_ff, neg_c_ff;
   logic        [62:0] lo_ff;
   logic        [94:0] hi_ff;
   logic        [63:0] r_ff;
   logic signed [63:0] p_ff;
   logic        [62:0] hi_part;
   logic        [95:0] prod;
   logic        [95:0] shifted;

   // upper partial product at full width
   assign hi_part = mag_ff[63:32] * gravity;

   // full product and scaling
   assign prod    = {1'b0, hi_ff} + {33'd0, lo_ff};
   assign shifted = prod >> swf_pkg::P_SHIFT;

   always_ff @(posedge clock) begin
      if (en) begin
         // difference of squares
         diff_ff  <= hh - zz;
         // magnitude and sign
         neg_a_ff <= diff_ff[63];
         mag_ff   <= diff_ff[63] ? (64'd0 - diff_ff) : diff_ff;
         // two partial products
         neg_b_ff <= neg_a_ff;
         lo_ff    <= mag_ff[31:0] * gravity;
         hi_ff    <= {hi_part, 32'd0};
         // clamp
         neg_c_ff <= neg_b_ff;
         r_ff     <= (shifted > {32'd0, swf_pkg::PCLAMP}) ? swf_pkg::PCLAMP
                                                          : shifted[63:0];
         // sign
         p_ff     <= neg_c_ff ? (64'd0 - r_ff) : r_ff;
      end
   end

   assign pressure = p_ff;

endmodule

`default_nettype wire

// ----- hdl/shallow_water_flux_2d_unit.sv -----
// ---------------------------------------------------------------------------
// shallow_water_flux_2d_unit
// Nodal x and y flux vectors of the 2D shallow water equations in Q16.16.
// ---------------------------------------------------------------------------
// One node enters per cycle and its result passes through one input
// register, one multiplier stage, then the 18-stage quotient divider (a
// magnitude stage, sixteen stages of four quotient bits and a sign restore
// stage) with the pressure path delayed alongside, and the saturating output
// register. Throughput is one node per cycle; a stall on the result side
// holds the whole pipeline. Configuration writes are taken at once and
// should only be made while no node is in flight.
`default_nettype none

module shallow_water_flux_2d_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   // input nodes
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // depth[31:0], flow_x[63:32], flow_y[95:64], bed_level[127:96]
   input  wire logic [127:0] req_tdata,
   // result items
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // mass_flux_x[31:0], momx_flux_x[63:32], momy_flux_x[95:64],
   // mass_flux_y[127:96], momx_flux_y[159:128], momy_flux_y[191:160]
   output logic [191:0]      rsp_tdata,
   // dry_node[0], saturated[1]
   output logic [1:0]        rsp_tuser,
   // configuration writes
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   localparam int DL = swf_pkg::DIV_LAT;

   typedef struct packed {
      logic [31:0] qx;
      logic [31:0] qy;
      logic        dry;
   } side_type;

   logic [30:0] wet_threshold_ff;
   logic [30:0] gravity_ff;
   logic        include_bed_ff;

   logic               en;
   logic               v1_ff, v2_ff;
   logic [DL:1]        vd_ff;
   logic signed [31:0] h1_ff, qx1_ff, qy1_ff, z1_ff;
   logic signed [63:0] pxx_ff, pxy_ff, pyy_ff, hh_ff, zz_ff;
   logic        [30:0] div_ff;
   side_type           s2_ff;
   side_type           sd_ff [1:DL];
   logic signed [63:0] pd_ff [1:swf_pkg::P_DELAY];
   logic signed [63:0] p_out, uu, uv, vv;
   logic [32:0]        sat_a, sat_b, sat_c;
   logic               out_v_ff;
   logic [191:0]       out_d_ff;
   logic [1:0]         out_u_ff;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         wet_threshold_ff <= swf_pkg::WET_THRESHOLD_RST;
         gravity_ff       <= swf_pkg::GRAVITY_RST;
         include_bed_ff   <= swf_pkg::INCLUDE_BED_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            swf_pkg::CSR_WET_THRESHOLD: wet_threshold_ff <= csr_data[30:0];
            swf_pkg::CSR_GRAVITY:       gravity_ff       <= csr_data[30:0];
            swf_pkg::CSR_INCLUDE_BED:   include_bed_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // pipeline advances unless the output register is held
   assign en         = !out_v_ff || rsp_tready;
   assign req_tready = en;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         vd_ff    <= '0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v1_ff    <= req_tvalid;
         v2_ff    <= v1_ff;
         vd_ff    <= {vd_ff[DL-1:1], v2_ff};
         out_v_ff <= vd_ff[DL];
      end
   end

   // input register and products
   always_ff @(posedge clock) begin
      if (en) begin
         h1_ff  <= req_tdata[31:0];
         qx1_ff <= req_tdata[63:32];
         qy1_ff <= req_tdata[95:64];
         z1_ff  <= include_bed_ff ? req_tdata[127:96] : 32'sd0;
         pxx_ff <= qx1_ff * qx1_ff;
         pxy_ff <= qx1_ff * qy1_ff;
         pyy_ff <= qy1_ff * qy1_ff;
         hh_ff  <= h1_ff * h1_ff;
         zz_ff  <= z1_ff * z1_ff;
         div_ff <= h1_ff[30:0];
         s2_ff.qx  <= qx1_ff;
         s2_ff.qy  <= qy1_ff;
         s2_ff.dry <= ($signed({h1_ff[31], h1_ff}) <= $signed({2'b00, wet_threshold_ff}));
      end
   end

   // quotients
   swf_div_pipe u_div_uu (.clock, .en, .dividend(pxx_ff), .divisor(div_ff), .quotient(uu));
   swf_div_pipe u_div_uv (.clock, .en, .dividend(pxy_ff), .divisor(div_ff), .quotient(uv));
   swf_div_pipe u_div_vv (.clock, .en, .dividend(pyy_ff), .divisor(div_ff), .quotient(vv));

   // pressure term
   swf_pressure u_pressure (
      .clock, .en, .hh(hh_ff), .zz(zz_ff), .gravity(gravity_ff), .pressure(p_out)
   );

   // delay lines matching the divider latency
   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[1] <= s2_ff;
         for (int k = 2; k <= DL; k++) begin
            sd_ff[k] <= sd_ff[k-1];
         end
         pd_ff[1] <= p_out;
         for (int k = 2; k <= swf_pkg::P_DELAY; k++) begin
            pd_ff[k] <= pd_ff[k-1];
         end
      end
   end

   // momentum sums with saturation
   assign sat_a = swf_pkg::sat32({uu[63], uu} + {pd_ff[swf_pkg::P_DELAY][63],
                                                 pd_ff[swf_pkg::P_DELAY]});
   assign sat_b = swf_pkg::sat32({uv[63], uv});
   assign sat_c = swf_pkg::sat32({vv[63], vv} + {pd_ff[swf_pkg::P_DELAY][63],
                                                 pd_ff[swf_pkg::P_DELAY]});

   // output register
   always_ff @(posedge clock) begin
      if (en) begin
         if (sd_ff[DL].dry) begin
            out_d_ff <= '0;
            out_u_ff <= 2'b01;
         end else begin
            out_d_ff <= {sat_c[31:0], sat_b[31:0], sd_ff[DL].qy,
                         sat_b[31:0], sat_a[31:0], sd_ff[DL].qx};
            out_u_ff <= {sat_a[32] | sat_b[32] | sat_c[32], 1'b0};
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_u_ff;

endmodule

`default_nettype wire

// ----- verif/swf_flux_checker.sv -----
// ---------------------------------------------------------------------------
// swf_flux_checker
// Watches the node, result and register channels of the flux unit, predicts
// the six fluxes and both flags of every accepted node, and compares each
// result transfer field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module swf_flux_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [127:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [191:0] rsp_tdata,
   input  wire logic [1:0]   rsp_tuser,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data,
   output int                mismatch_count,
   output int                flux_pending
);

   typedef struct packed {
      logic [31:0] mass_x;
      logic [31:0] momx_x;
      logic [31:0] momy_x;
      logic [31:0] mass_y;
      logic [31:0] momx_y;
      logic [31:0] momy_y;
      logic        dry;
      logic        sat;
   } flux_item_type;

   flux_item_type flux_expected[$];
   logic [30:0]   wet_thr;
   logic [30:0]   grav;
   logic          bed_on;

   // sign extend a 32-bit raw value
   function automatic logic signed [79:0] sx(logic [31:0] v);
      return {{48{v[31]}}, v};
   endfunction

   // g * d / 2^(2F+1) truncated toward zero, magnitude bounded
   function automatic logic signed [79:0] pressure_term(logic signed [79:0] d,
                                                       logic [30:0] g);
      logic [127:0] mag;
      logic [127:0] prod;
      logic [79:0]  r;
      mag  = d < 0 ? 128'(-d) : 128'(d);
      prod = mag * {97'd0, g};
      prod = prod >> swf_pkg::P_SHIFT;
      if (prod > {64'd0, swf_pkg::PCLAMP}) prod = {64'd0, swf_pkg::PCLAMP};
      r = prod[79:0];
      return d < 0 ? -$signed(r) : $signed(r);
   endfunction

   // clip to the 32-bit signed range
   function automatic logic [31:0] clip32(logic signed [79:0] v, inout logic flag);
      if (v > 80'sd2147483647) begin
         flag = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -80'sd2147483648) begin
         flag = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic flux_item_type predict_fluxes(logic [127:0] node);
      flux_item_type      f;
      logic signed [79:0] h, qx, qy, z, p, uu, uv, vv, thr;
      logic               s;
      f   = '0;
      s   = 1'b0;
      h   = sx(node[31:0]);
      qx  = sx(node[63:32]);
      qy  = sx(node[95:64]);
      z   = bed_on ? sx(node[127:96]) : 80'sd0;
      thr = $signed({49'd0, wet_thr});
      if (h <= thr) begin
         f.dry = 1'b1;
         return f;
      end
      p  = pressure_term(h * h - z * z, grav);
      uu = (qx * qx) / h;
      uv = (qx * qy) / h;
      vv = (qy * qy) / h;
      f.mass_x = node[63:32];
      f.momx_x = clip32(uu + p, s);
      f.momy_x = clip32(uv, s);
      f.mass_y = node[95:64];
      f.momx_y = clip32(uv, s);
      f.momy_y = clip32(vv + p, s);
      f.sat    = s;
      return f;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // register shadow, prediction on node transfers, compare on result transfers
   always @(posedge clock) begin
      flux_item_type e;
      if (reset) begin
         flux_expected.delete();
         wet_thr        <= swf_pkg::WET_THRESHOLD_RST;
         grav           <= swf_pkg::GRAVITY_RST;
         bed_on         <= swf_pkg::INCLUDE_BED_RST;
         mismatch_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               swf_pkg::CSR_WET_THRESHOLD: wet_thr <= csr_data[30:0];
               swf_pkg::CSR_GRAVITY:       grav    <= csr_data[30:0];
               swf_pkg::CSR_INCLUDE_BED:   bed_on  <= csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) flux_expected.push_back(predict_fluxes(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (flux_expected.size() == 0) begin
               $error("result transfer with no node outstanding");
               mismatch_count++;
            end else begin
               e = flux_expected.pop_front();
               check_field("mass_flux_x", e.mass_x, rsp_tdata[31:0]);
               check_field("momx_flux_x", e.momx_x, rsp_tdata[63:32]);
               check_field("momy_flux_x", e.momy_x, rsp_tdata[95:64]);
               check_field("mass_flux_y", e.mass_y, rsp_tdata[127:96]);
               check_field("momx_flux_y", e.momx_y, rsp_tdata[159:128]);
               check_field("momy_flux_y", e.momy_y, rsp_tdata[191:160]);
               check_field("dry_node", {31'd0, e.dry}, {31'd0, rsp_tuser[0]});
               check_field("saturated", {31'd0, e.sat}, {31'd0, rsp_tuser[1]});
            end
         end
      end
      flux_pending <= flux_expected.size();
   end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the shallow water flux unit: directed corner
// nodes, then random nodes over several register settings, with bursty
// input, a stalling result side and one long result hold-off.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // depth, flow_x, flow_y, bed_level
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // six fluxes, lowest first
   logic [191:0] rsp_tdata;
   // dry_node, saturated
   logic [1:0]   rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [31:0]  csr_data;
   int           mismatch_count;
   int           flux_pending;
   logic         hold_request;

   shallow_water_flux_2d_unit uut (.*);

   swf_flux_checker chk (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #3000000;
      $display("Regression FAIL");
      $finish;
   end

   // result side: changing stall pattern plus a long hold-off on request
   initial begin
      int cyc;
      int hold_left;
      int mode;
      cyc = 0;
      hold_left = 0;
      mode = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 97 == 0) mode = $urandom_range(0, 3);
         if (hold_request && hold_left == 0) hold_left = 300;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 4) == 0);
               default: rsp_tready <= (cyc % 3 != 0);
            endcase
         end
      end
   end

   task automatic wait_idle();
      do @(negedge clock); while (flux_pending != 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      logic ok;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      csr_valid <= 1'b0;
   endtask

   task automatic send_node(logic [31:0] h, logic [31:0] qx, logic [31:0] qy,
                            logic [31:0] z);
      logic ok;
      req_tvalid <= 1'b1;
      req_tdata  <= {z, qy, qx, h};
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // random node: mostly wet with moderate values, some full-range noise
   task automatic random_node();
      logic [31:0] h, qx, qy, z;
      int k;
      k = $urandom_range(0, 9);
      if (k < 6) begin
         h  = $urandom_range(1, 32'h00FF_FFFF);
         qx = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         qy = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         z  = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      end else if (k < 8) begin
         h  = {1'b0, 31'($urandom())};
         qx = $urandom();
         qy = $urandom();
         z  = $urandom();
      end else begin
         h  = $urandom();
         qx = $urandom();
         qy = $urandom();
         z  = $urandom();
      end
      send_node(h, qx, qy, z);
   endtask

   task automatic random_phase(int count);
      int burst;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 16);
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
         end
         random_node();
         burst--;
      end
      idle_gap(1);
   endtask

   task automatic set_regs(logic [31:0] thr, logic [31:0] g, logic [31:0] bed);
      wait_idle();
      write_reg(swf_pkg::CSR_WET_THRESHOLD, thr);
      write_reg(swf_pkg::CSR_GRAVITY, g);
      write_reg(swf_pkg::CSR_INCLUDE_BED, bed);
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = swf_pkg::CSR_WET_THRESHOLD;
      csr_data     = '0;
      hold_request = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners at reset settings
      send_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_node(32'h8000_0000, 32'h1234_5678, 32'h8765_4321, 32'h0);
      send_node(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_node(32'd7, 32'h0001_0000, 32'h0001_0000, 32'h0);
      send_node(32'd8, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
      send_node(32'd8, 32'h8000_0000, 32'h8000_0000, 32'h0);
      send_node(32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0005_0000);
      send_node(32'h0001_0000, 32'h0, 32'h0, 32'h7FFF_FFFF);
      send_node(32'h0001_0000, 32'h0, 32'h0, 32'h8000_0000);
      send_node(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
      send_node(32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0002_0000);
      send_node(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_node(32'h0003_0000, 32'h0001_8000, 32'hFFFE_8000, 32'h0001_0000);
      idle_gap(1);
      random_phase(60);

      // long result hold-off while nodes keep coming
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      random_phase(60);

      // zero threshold, maximum gravity, reduced form
      set_regs(32'h0, 32'h7FFF_FFFF, 32'h0);
      send_node(32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_node(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000);
      send_node(32'h0, 32'h1, 32'h1, 32'h1);
      idle_gap(1);
      random_phase(70);

      // maximum threshold, zero gravity: every node dry
      set_regs(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE);
      send_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
      idle_gap(1);
      random_phase(30);

      // random settings with the bed term on
      set_regs($urandom_range(0, 32'h0000_FFFF), $urandom(), 32'h1);
      random_phase(70);

      // back to reset values, pause until drained, then more
      set_regs({1'b1, swf_pkg::WET_THRESHOLD_RST}, {1'b1, swf_pkg::GRAVITY_RST}, 32'h1);
      random_phase(40);
      wait_idle();
      random_phase(40);

      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
